// ===== src/mpa_pkg.sv =====
// shared types, constants and helper functions of the max pooling block
// depends on nothing; every other file refers to it by scoped names
package mpa_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_KERNEL = 8;
	localparam int DATA_W         = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int DIM_REG_W  = 9;
	localparam int WIN_REG_W  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_HEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP  = 2'd3;

	localparam logic [DIM_REG_W-1:0] RST_PLANE_HEIGHT = 9'd28;
	localparam logic [DIM_REG_W-1:0] RST_PLANE_WIDTH  = 9'd28;
	localparam logic [WIN_REG_W-1:0] RST_WINDOW_SIZE  = 4'd2;
	localparam logic [WIN_REG_W-1:0] RST_WINDOW_STEP  = 4'd2;

	// job fields sized for the largest supported geometry
	localparam int JOB_SLOT_W = 4;
	localparam int JOB_COL_W  = 12;
	localparam int JOB_K_W    = 5;
	localparam int JOB_DIM_W  = 13;
	localparam int JOB_QUEUE_DEPTH = 4;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic                     tensor_start;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] window_max;
		logic [31:0]              max_position;
		logic                     plane_done;
	} out_item_t;

	typedef struct packed {
		logic [JOB_SLOT_W-1:0] start_slot;
		logic [JOB_COL_W-1:0]  start_col;
		logic [JOB_K_W-1:0]    size;
		logic [JOB_DIM_W-1:0]  width;
		logic [31:0]           position;
		logic                  last;
	} job_t;

	function automatic logic [15:0] clamp_dim(input logic [15:0] v, input logic [15:0] hi);
		logic [15:0] r;
		if (v == 16'd0) begin
			r = 16'd1;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// one restoring step of a remainder by a 4-bit divisor
	function automatic logic [3:0] mod_step(input logic [3:0] rem, input logic bit_in,
			input logic [3:0] d);
		logic [4:0] t;
		t = {rem, bit_in};
		if (t >= {1'b0, d}) begin
			t = t - {1'b0, d};
		end
		return t[3:0];
	endfunction

	function automatic logic [3:0] mod_small(input logic [3:0] a, input logic [3:0] d);
		logic [3:0] rem;
		rem = 4'd0;
		for (int b = 3; b >= 0; b--) begin
			rem = mod_step(rem, a[b], d);
		end
		return rem;
	endfunction

endpackage

// ===== src/mpa_ram.sv =====
// generic single-write, single-read memory with registered read data
// depends on mpa_pkg for default sizes
module mpa_ram #(
	parameter int WIDTH = mpa_pkg::DATA_W,
	parameter int DEPTH = mpa_pkg::DEF_MAX_KERNEL * mpa_pkg::DEF_MAX_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/mpa_queue.sv =====
// short job queue between the front and the back of the pooling block
// depends on mpa_pkg for the job type and depth
module mpa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mpa_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output mpa_pkg::job_t pop_job,
	output logic          empty
);

	localparam int DEPTH = mpa_pkg::JOB_QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	mpa_pkg::job_t  slot_q [DEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [NW-1:0]  cnt_q;

	assign full    = (cnt_q == NW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== src/mpa_front.sv =====
// front of the pooling block: configuration, plane counters, row store writes
// and detection of completed windows; depends on mpa_pkg
module mpa_front #(
	parameter int MAX_WIDTH  = mpa_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mpa_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = mpa_pkg::DEF_MAX_KERNEL,
	parameter int AW         = 11
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mpa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  mpa_pkg::in_item_t                in_data,
	input  logic                             back_quiet,
	input  logic                             q_full,
	output logic                             push,
	output mpa_pkg::job_t                    push_job,
	output logic                             ram_we,
	output logic [AW-1:0]                    ram_waddr,
	output logic [mpa_pkg::DATA_W-1:0]       ram_wdata
);

	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int DW  = (RW > CW) ? RW : CW;
	localparam int NW  = $clog2(DW + 1);

	logic [mpa_pkg::DIM_REG_W-1:0] height_q;
	logic [mpa_pkg::DIM_REG_W-1:0] width_q;
	logic [mpa_pkg::WIN_REG_W-1:0] ksize_q;
	logic [mpa_pkg::WIN_REG_W-1:0] kstep_q;

	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic [SLW-1:0] slot_q;
	logic [3:0]     rph_q;
	logic [3:0]     cph_q;
	logic [31:0]    base_q;
	logic [31:0]    plane_size_q;

	// remainder recompute after a configuration write
	logic           recalc_q;
	logic [NW-1:0]  rcnt_q;
	logic [DW-1:0]  rsh_q;
	logic [DW-1:0]  csh_q;
	logic [3:0]     rrem_q;
	logic [3:0]     crem_q;
	logic [3:0]     rrem_n;
	logic [3:0]     crem_n;

	logic [15:0] h16, w16, k16, s16;
	logic [3:0]  s4, km1, kphase;
	logic        tensor;
	logic [15:0] r16, c16;
	logic [SLW-1:0] slot;
	logic [3:0]  pr, pc;
	logic [31:0] base;
	logic        fire;
	logic [15:0] sh16, sw16, ss16;
	logic [31:0] prod;
	logic        done;
	logic        accept;
	logic        c_wrap, r_wrap;

	assign h16    = mpa_pkg::clamp_dim(16'(height_q), 16'(MAX_HEIGHT));
	assign w16    = mpa_pkg::clamp_dim(16'(width_q), 16'(MAX_WIDTH));
	assign k16    = mpa_pkg::clamp_dim(16'(ksize_q), 16'(MAX_KERNEL));
	assign s4     = (kstep_q == '0) ? 4'd1 : kstep_q;
	assign s16    = 16'(s4);
	assign km1    = 4'(k16 - 16'd1);
	assign kphase = mpa_pkg::mod_small(km1, s4);

	assign tensor = in_data.tensor_start;
	assign r16    = tensor ? 16'd0 : 16'(row_q);
	assign c16    = tensor ? 16'd0 : 16'(col_q);
	assign slot   = tensor ? '0 : slot_q;
	assign pr     = tensor ? 4'd0 : rph_q;
	assign pc     = tensor ? 4'd0 : cph_q;
	assign base   = tensor ? 32'd0 : base_q;

	// a window ends here when both counters sit at (k-1) modulo the step
	assign fire = (k16 <= h16) && (k16 <= w16) && (r16 + 16'd1 >= k16)
		&& (c16 + 16'd1 >= k16) && (pr == kphase) && (pc == kphase);
	assign sh16 = r16 + 16'd1 - k16;
	assign sw16 = c16 + 16'd1 - k16;
	assign ss16 = (16'(slot) >= 16'(km1)) ? 16'(slot) - 16'(km1)
		: 16'(slot) + 16'(MAX_KERNEL) - 16'(km1);
	assign prod = 32'(sh16) * 32'(w16);
	// last window start is the one whose next step would overrun the plane
	assign done = (r16 < h16) && (r16 + s16 >= h16) && (c16 < w16) && (c16 + s16 >= w16);

	assign c_wrap = (c16 + 16'd1 >= w16);
	assign r_wrap = (r16 + 16'd1 >= h16);

	// a new row must not overwrite slots that queued windows still read
	assign in_ready = !recalc_q && !q_full && !((tensor || col_q == '0) && !back_quiet);
	assign accept   = in_valid && in_ready;

	assign push                = accept && fire;
	assign push_job.start_slot = mpa_pkg::JOB_SLOT_W'(ss16);
	assign push_job.start_col  = mpa_pkg::JOB_COL_W'(sw16);
	assign push_job.size       = mpa_pkg::JOB_K_W'(k16);
	assign push_job.width      = mpa_pkg::JOB_DIM_W'(w16);
	assign push_job.position   = base + prod + 32'(sw16);
	assign push_job.last       = done;

	assign ram_we    = accept;
	assign ram_waddr = AW'(slot) * AW'(MAX_WIDTH) + AW'(c16);
	assign ram_wdata = in_data.sample;

	assign rrem_n = mpa_pkg::mod_step(rrem_q, rsh_q[DW-1], s4);
	assign crem_n = mpa_pkg::mod_step(crem_q, csh_q[DW-1], s4);

	always_ff @(posedge clk) begin
		plane_size_q <= 32'(h16) * 32'(w16);
		if (cfg_we) begin
			rsh_q  <= DW'(row_q);
			csh_q  <= DW'(col_q);
			rrem_q <= 4'd0;
			crem_q <= 4'd0;
		end else if (recalc_q) begin
			rsh_q  <= rsh_q << 1;
			csh_q  <= csh_q << 1;
			rrem_q <= rrem_n;
			crem_q <= crem_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= mpa_pkg::RST_PLANE_HEIGHT;
			width_q  <= mpa_pkg::RST_PLANE_WIDTH;
			ksize_q  <= mpa_pkg::RST_WINDOW_SIZE;
			kstep_q  <= mpa_pkg::RST_WINDOW_STEP;
			row_q    <= '0;
			col_q    <= '0;
			slot_q   <= '0;
			rph_q    <= '0;
			cph_q    <= '0;
			base_q   <= '0;
			recalc_q <= 1'b0;
			rcnt_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					mpa_pkg::REG_PLANE_HEIGHT: height_q <= cfg_data;
					mpa_pkg::REG_PLANE_WIDTH:  width_q  <= cfg_data;
					mpa_pkg::REG_WINDOW_SIZE:  ksize_q  <= cfg_data[mpa_pkg::WIN_REG_W-1:0];
					mpa_pkg::REG_WINDOW_STEP:  kstep_q  <= cfg_data[mpa_pkg::WIN_REG_W-1:0];
				endcase
				recalc_q <= 1'b1;
				rcnt_q   <= NW'(DW);
			end else if (recalc_q) begin
				rcnt_q <= rcnt_q - 1'b1;
				if (rcnt_q == NW'(1)) begin
					recalc_q <= 1'b0;
					rph_q    <= rrem_n;
					cph_q    <= crem_n;
				end
			end
			if (accept) begin
				if (c_wrap) begin
					col_q <= '0;
					cph_q <= 4'd0;
					if (r_wrap) begin
						row_q  <= '0;
						slot_q <= '0;
						rph_q  <= 4'd0;
						base_q <= base + plane_size_q;
					end else begin
						row_q  <= RW'(r16 + 16'd1);
						slot_q <= (slot == SLW'(MAX_KERNEL - 1)) ? '0 : slot + 1'b1;
						rph_q  <= (pr + 4'd1 == s4) ? 4'd0 : pr + 4'd1;
						base_q <= base;
					end
				end else begin
					col_q  <= CW'(c16 + 16'd1);
					cph_q  <= (pc + 4'd1 == s4) ? 4'd0 : pc + 4'd1;
					row_q  <= RW'(r16);
					slot_q <= slot;
					rph_q  <= pr;
					base_q <= base;
				end
			end
		end
	end

endmodule

// ===== src/mpa_back.sv =====
// back of the pooling block: scans one window of the row store per job and
// keeps the running maximum and its position; depends on mpa_pkg
module mpa_back #(
	parameter int MAX_WIDTH  = mpa_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL = mpa_pkg::DEF_MAX_KERNEL,
	parameter int AW         = 11
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	output logic                        pop,
	input  mpa_pkg::job_t               pop_job,
	output logic [AW-1:0]               ram_raddr,
	input  logic [mpa_pkg::DATA_W-1:0]  ram_rdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output mpa_pkg::out_item_t          out_data,
	output logic                        idle
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int KW  = $clog2(MAX_KERNEL + 1);

	logic           busy_q;
	logic [KW-1:0]  i_q, j_q, k_q;
	logic [SLW-1:0] slot_q;
	logic [CW-1:0]  col_q, scol_q;
	logic [WW-1:0]  w_q;
	logic [31:0]    rowpos_q;
	logic           last_q;

	logic           valid_s1;
	logic [31:0]    pos_s1;
	logic           first_s1;
	logic           final_s1;

	logic signed [mpa_pkg::DATA_W-1:0] best_q;
	logic [31:0]                       bpos_q;
	logic                              out_valid_q;
	mpa_pkg::out_item_t                out_q;

	logic                              row_end, elem_last, take;
	logic signed [mpa_pkg::DATA_W-1:0] nbest;
	logic [31:0]                       npos;

	assign pop = !busy_q && !valid_s1 && !q_empty && (!out_valid_q || out_ready);
	assign idle = !busy_q && !valid_s1;

	assign ram_raddr = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_q);
	assign row_end   = (j_q == k_q - 1'b1);
	assign elem_last = row_end && (i_q == k_q - 1'b1);

	// strict greater keeps the first maximal element
	assign take  = first_s1 || ($signed(ram_rdata) > best_q);
	assign nbest = take ? $signed(ram_rdata) : best_q;
	assign npos  = take ? pos_s1 : bpos_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		pos_s1   <= rowpos_q + 32'(j_q);
		first_s1 <= (i_q == '0) && (j_q == '0);
		final_s1 <= elem_last;
		if (valid_s1) begin
			best_q <= nbest;
			bpos_q <= npos;
		end
		if (valid_s1 && final_s1) begin
			out_q.window_max   <= nbest;
			out_q.max_position <= npos;
			out_q.plane_done   <= last_q;
		end
		if (pop) begin
			k_q      <= KW'(pop_job.size);
			scol_q   <= CW'(pop_job.start_col);
			w_q      <= WW'(pop_job.width);
			last_q   <= pop_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			slot_q      <= '0;
			col_q       <= '0;
			rowpos_q    <= '0;
		end else begin
			valid_s1 <= busy_q;
			if (pop) begin
				busy_q   <= 1'b1;
				i_q      <= '0;
				j_q      <= '0;
				slot_q   <= SLW'(pop_job.start_slot);
				col_q    <= CW'(pop_job.start_col);
				rowpos_q <= pop_job.position;
			end else if (busy_q) begin
				if (row_end) begin
					j_q      <= '0;
					col_q    <= scol_q;
					i_q      <= i_q + 1'b1;
					slot_q   <= (slot_q == SLW'(MAX_KERNEL - 1)) ? '0 : slot_q + 1'b1;
					rowpos_q <= rowpos_q + 32'(w_q);
					if (elem_last) begin
						busy_q <= 1'b0;
					end
				end else begin
					j_q   <= j_q + 1'b1;
					col_q <= col_q + 1'b1;
				end
			end
			if (valid_s1 && final_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/max_pool_2d_argmax_top.sv =====
// throughput: one element per cycle into the front while in_ready is high; the back scans
// one stored element per cycle and takes no new job before it is through with the last;
// an element starting a row waits until the back drains
// a configuration write holds off input while the counter phases are recomputed
// reset: registers return to 28/28/2/2, counters clear; the row store is not cleared
// top level of the max pooling block; depends on mpa_pkg, mpa_front, mpa_queue, mpa_back, mpa_ram
module max_pool_2d_argmax_top #(
	parameter int MAX_WIDTH  = mpa_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = mpa_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = mpa_pkg::DEF_MAX_KERNEL
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  mpa_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output mpa_pkg::out_item_t             out_data
);

	localparam int DEPTH = MAX_KERNEL * MAX_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                        push, pop, q_full, q_empty, back_idle, back_quiet;
	mpa_pkg::job_t               push_job, pop_job;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr, ram_raddr;
	logic [mpa_pkg::DATA_W-1:0]  ram_wdata, ram_rdata;

	assign back_quiet = q_empty && back_idle;

	mpa_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_KERNEL (MAX_KERNEL),
		.AW         (AW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.back_quiet (back_quiet),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	mpa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (q_empty)
	);

	mpa_ram #(
		.WIDTH (mpa_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mpa_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_KERNEL (MAX_KERNEL),
		.AW         (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.pop       (pop),
		.pop_job   (pop_job),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.idle      (back_idle)
	);

endmodule

// ===== dv/max_pool_2d_argmax_top_test.sv =====
// self-checking testbench for the max pooling block with argmax
// depends on mpa_pkg and max_pool_2d_argmax_top; predicts every window in the bench
// and checks each result against the oldest outstanding request
module max_pool_2d_argmax_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W = mpa_pkg::DEF_MAX_WIDTH;
	localparam int MAX_H = mpa_pkg::DEF_MAX_HEIGHT;
	localparam int MAX_K = mpa_pkg::DEF_MAX_KERNEL;
	localparam int ROW_WORDS = MAX_K * MAX_W;
	localparam int SETTLE_CYCLES = 150;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ELEMENTS = 1680;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [mpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	mpa_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	mpa_pkg::out_item_t out_data;

	// bench copy of the block state
	logic [31:0] line_buf [0:ROW_WORDS-1];
	logic [8:0] height_reg = mpa_pkg::RST_PLANE_HEIGHT;
	logic [8:0] width_reg = mpa_pkg::RST_PLANE_WIDTH;
	logic [3:0] size_reg = mpa_pkg::RST_WINDOW_SIZE;
	logic [3:0] step_reg = mpa_pkg::RST_WINDOW_STEP;
	int unsigned row_pos = 0;
	int unsigned col_pos = 0;
	logic [31:0] plane_base = '0;

	mpa_pkg::out_item_t pending_windows [$];
	int unsigned mismatch_count = 0;
	int unsigned elements_sent = 0;
	int unsigned cycle_count = 0;
	bit send_gaps = 1'b1;
	bit ready_gaps = 1'b1;

	max_pool_2d_argmax_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("max_pool_2d_argmax_top_test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic int unsigned bound_dim(input int unsigned v, input int unsigned hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	// store one element, queue the window it completes if any, advance the raster position
	function automatic void pool_element(input logic [31:0] value, input logic first);
		int unsigned h, w, k, s, r, c, top, left;
		logic signed [31:0] best;
		logic [31:0] best_at;
		mpa_pkg::out_item_t win;
		h = bound_dim(height_reg, MAX_H);
		w = bound_dim(width_reg, MAX_W);
		k = bound_dim(size_reg, MAX_K);
		s = (step_reg == 0) ? 1 : step_reg;
		if (first) begin
			row_pos = 0;
			col_pos = 0;
			plane_base = '0;
		end
		r = row_pos;
		c = col_pos;
		line_buf[(r % MAX_K) * MAX_W + c] = value;
		if (k <= h && k <= w && r + 1 >= k && c + 1 >= k &&
				(r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
			top = r + 1 - k;
			left = c + 1 - k;
			best = line_buf[(top % MAX_K) * MAX_W + left];
			best_at = plane_base + top * w + left;
			// row-major scan, strict compare keeps the first maximum
			for (int i = 0; i < k; i++) begin
				for (int j = 0; j < k; j++) begin
					if ($signed(line_buf[((top + i) % MAX_K) * MAX_W + left + j]) > best) begin
						best = line_buf[((top + i) % MAX_K) * MAX_W + left + j];
						best_at = plane_base + (top + i) * w + left + j;
					end
				end
			end
			win.window_max = best;
			win.max_position = best_at;
			win.plane_done = (top == ((h - k) / s) * s && left == ((w - k) / s) * s);
			pending_windows.push_back(win);
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			if (r + 1 >= h) begin
				row_pos = 0;
				plane_base = plane_base + h * w;
			end else begin
				row_pos = r + 1;
			end
		end else begin
			col_pos = c + 1;
		end
	endfunction

	task automatic send_element(input logic [31:0] value, input logic first);
		int unsigned gap;
		gap = send_gaps ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pool_element(value, first);
		in_valid <= 1'b1;
		in_data.sample <= value;
		in_data.tensor_start <= first;
		do @(posedge clk); while (in_ready !== 1'b1);
		elements_sent++;
	endtask

	task automatic drain_windows();
		in_valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		// elements that complete no window may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(input logic [8:0] h, input logic [8:0] w,
			input logic [3:0] k, input logic [3:0] s);
		logic [4:0] junk;
		drain_windows();
		cfg_we <= 1'b1;
		cfg_index <= mpa_pkg::REG_PLANE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= mpa_pkg::REG_PLANE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		// upper data bits are don't-care for the window registers
		junk = 5'($urandom);
		cfg_index <= mpa_pkg::REG_WINDOW_SIZE;
		cfg_data <= {junk, k};
		@(posedge clk);
		junk = 5'($urandom);
		cfg_index <= mpa_pkg::REG_WINDOW_STEP;
		cfg_data <= {junk, s};
		@(posedge clk);
		cfg_we <= 1'b0;
		height_reg = h;
		width_reg = w;
		size_reg = k;
		step_reg = s;
	endtask

	function automatic logic [31:0] random_sample(input bit narrow);
		logic [31:0] v;
		if (narrow) begin
			v = $urandom_range(0, 6) - 3;
		end else begin
			case ($urandom_range(0, 15))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				default: v = $urandom;
			endcase
		end
		return v;
	endfunction

	function automatic logic [8:0] random_dim();
		case ($urandom_range(0, 11))
			0: return 9'd0;
			1: return 9'd511;
			2: return 9'd256;
			3: return 9'd1;
			4: return 9'($urandom_range(1, 511));
			default: return 9'($urandom_range(2, 12));
		endcase
	endfunction

	function automatic logic [3:0] random_window();
		case ($urandom_range(0, 9))
			0: return 4'd0;
			1: return 4'd15;
			2: return 4'd8;
			3: return 4'($urandom_range(0, 15));
			default: return 4'($urandom_range(1, 3));
		endcase
	endfunction

	// reset geometry, first element without a tensor start
	task automatic test_reset_geometry();
		for (int n = 0; n < 60; n++) begin
			send_element(random_sample(n % 3 == 0), 1'b0);
		end
	endtask

	task automatic test_ties_and_extremes();
		set_geometry(9'd2, 9'd4, 4'd2, 4'd2);
		send_element(32'h7FFF_FFFF, 1'b1);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h8000_0000, 1'b0);
		send_element(32'h8000_0000, 1'b0);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h8000_0000, 1'b0);
		send_element(32'h8000_0001, 1'b0);
	endtask

	// zero height, size and step fall back to one: every element is its own window
	task automatic test_unit_window();
		set_geometry(9'd0, 9'd5, 4'd0, 4'd0);
		send_element(32'hFFFF_FFFF, 1'b1);
		send_element(32'h0000_0000, 1'b0);
		send_element(32'h0000_0001, 1'b0);
		send_element(32'h8000_0000, 1'b0);
		send_element(32'h7FFF_FFFF, 1'b0);
		send_element(32'h0001_2345, 1'b0);
	endtask

	task automatic test_oversized_window();
		set_geometry(9'd3, 9'd3, 4'd15, 4'd1);
		for (int n = 0; n < 9; n++) begin
			send_element(random_sample(1'b0), n == 0);
		end
	endtask

	// last row completes no window
	task automatic test_trailing_elements();
		set_geometry(9'd3, 9'd5, 4'd2, 4'd3);
		for (int n = 0; n < 15; n++) begin
			send_element(random_sample(1'b0), n == 0);
		end
	endtask

	// width shrinks to the column counter's value mid-plane; it wraps at the new bound
	task automatic test_midplane_resize();
		set_geometry(9'd4, 9'd6, 4'd2, 4'd2);
		for (int n = 0; n < 9; n++) begin
			send_element(random_sample(1'b0), n == 0);
		end
		set_geometry(9'd4, 9'd3, 4'd2, 4'd2);
		for (int n = 0; n < 7; n++) begin
			send_element(random_sample(1'b0), 1'b0);
		end
	endtask

	task automatic test_random_geometry();
		int unsigned target, count;
		bit narrow;
		target = elements_sent + RANDOM_ELEMENTS;
		while (elements_sent < target) begin
			set_geometry(random_dim(), random_dim(), random_window(), random_window());
			send_gaps = ($urandom_range(0, 4) != 0);
			ready_gaps = ($urandom_range(0, 4) != 0);
			narrow = ($urandom_range(0, 3) == 0);
			count = $urandom_range(40, 160);
			for (int n = 0; n < count; n++) begin
				// occasional restart inside a plane
				send_element(random_sample(narrow), n == 0 || $urandom_range(0, 63) == 0);
			end
		end
		send_gaps = 1'b1;
		ready_gaps = 1'b1;
	endtask

	initial begin : drive_ready
		int unsigned stall;
		forever begin
			stall = ready_gaps ? $urandom_range(0, 8) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	always @(posedge clk) begin : check_windows
		mpa_pkg::out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pending_windows.size() == 0) begin
				report_mismatch($sformatf("window %h/%h with no request pending",
					out_data.window_max, out_data.max_position));
			end else begin
				want = pending_windows.pop_front();
				if (out_data.window_max !== want.window_max) begin
					report_mismatch($sformatf("window_max got %h want %h",
						out_data.window_max, want.window_max));
				end
				if (out_data.max_position !== want.max_position) begin
					report_mismatch($sformatf("max_position got %0d want %0d",
						out_data.max_position, want.max_position));
				end
				if (out_data.plane_done !== want.plane_done) begin
					report_mismatch($sformatf("plane_done got %b want %b",
						out_data.plane_done, want.plane_done));
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_geometry();
		test_ties_and_extremes();
		test_unit_window();
		test_oversized_window();
		test_trailing_elements();
		test_midplane_resize();
		test_random_geometry();
		drain_windows();
		if (mismatch_count == 0) begin
			$display("max_pool_2d_argmax_top_test passed");
		end else begin
			$display("max_pool_2d_argmax_top_test failed");
		end
		$finish;
	end

endmodule
